/* rtl/baro_pressure_temp_compensation_core_macros.svh */
// assertion macros shared by the checker of the compensation core
// no dependencies; take in with an include of the bare file name
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH

// clocked property, switched off while reset is high
`define BPTC_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("bptc check failed");

// clocked property that holds through reset as well
`define BPTC_ASSERT_ALL(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("bptc check failed");

`endif

/* rtl/bptc_pkg.sv */
// shared constants and types for the barometric compensation core
// no dependencies
package bptc_pkg;

   // field widths
   localparam int RAW_W   = 24;
   localparam int Q_W     = 32;
   localparam int ACC_W   = 56;
   localparam int MAG_W   = 56;
   localparam int TEMP_W  = 16;
   localparam int PRESS_W = 21;

   // csr port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   // divider: one leading quotient bit, then DIV_STEP bits in each of DIV_STAGES stages
   localparam int DIV_STEP   = 3;
   localparam int DIV_STAGES = 10;
   localparam int DIV_QB     = 1 + DIV_STEP * DIV_STAGES;
   localparam int DIV_LAT    = DIV_STAGES + 3;

   // item latency from acceptance to result strobe
   localparam int LATENCY = 26;

   localparam logic [RAW_W-1:0] RAW_SCALE_RESET = 24'd3670016;
   localparam logic [PRESS_W-1:0] PRESS_MAX = 21'h1FFFFF;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef enum logic [2:0] {
      REG_RAW_SCALE = 3'd0,
      REG_TEMP      = 3'd1,
      REG_PBASE     = 3'd2,
      REG_PCROSS    = 3'd3,
      REG_PSECOND   = 3'd4,
      REG_PCUBIC    = 3'd5
   } reg_idx_type;

endpackage

/* rtl/bptc_div.sv */
// pipelined restoring divider: (raw * 2^30) / divisor, truncated and saturated to Q2.30
// depends on bptc_pkg
module bptc_div (
   input  logic                                 clock,
   input  logic signed [bptc_pkg::RAW_W-1:0]    raw,
   input  logic        [bptc_pkg::RAW_W-1:0]    divisor,
   output logic signed [bptc_pkg::Q_W-1:0]      quot
);

   localparam int QB = bptc_pkg::DIV_QB;
   localparam int NS = bptc_pkg::DIV_STAGES;

   logic [bptc_pkg::RAW_W-1:0] abs_ff;
   logic                       sgn_ff;

   logic [bptc_pkg::RAW_W-1:0] rem_ff [0:NS];
   logic [QB-1:0]              quo_ff [0:NS];
   logic                       neg_ff [0:NS];
   logic                       sat_ff [0:NS];

   logic [bptc_pkg::RAW_W-1:0] rem_in [0:NS-1];
   logic [QB-1:0]              quo_in [0:NS-1];

   logic                       lead_bit;
   logic                       sat_in;

   // magnitude of the reading
   always_ff @(posedge clock) begin
      abs_ff <= raw[bptc_pkg::RAW_W-1] ? bptc_pkg::RAW_W'(-raw) : bptc_pkg::RAW_W'(raw);
      sgn_ff <= raw[bptc_pkg::RAW_W-1];
   end

   // leading quotient bit and overflow test: quotient reaches 2^31 when |raw| >= 2*divisor
   always_comb begin
      lead_bit = abs_ff >= divisor;
      sat_in   = {1'b0, abs_ff} >= {divisor, 1'b0};
   end

   // DIV_STEP compare and subtract steps per stage
   always_comb begin
      logic [bptc_pkg::RAW_W-1:0] r;
      logic [bptc_pkg::RAW_W:0]   r2;
      logic [QB-1:0]              qv;
      for (int s = 0; s < NS; s++) begin
         r  = rem_ff[s];
         qv = quo_ff[s];
         for (int b = 0; b < bptc_pkg::DIV_STEP; b++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, divisor}) begin
               r  = bptc_pkg::RAW_W'(r2 - {1'b0, divisor});
               qv = {qv[QB-2:0], 1'b1};
            end else begin
               r  = r2[bptc_pkg::RAW_W-1:0];
               qv = {qv[QB-2:0], 1'b0};
            end
         end
         rem_in[s] = r;
         quo_in[s] = qv;
      end
   end

   // first stage takes the leading bit, later stages the step results
   always_ff @(posedge clock) begin
      rem_ff[0] <= lead_bit ? abs_ff - divisor : abs_ff;
      quo_ff[0] <= QB'(lead_bit);
      neg_ff[0] <= sgn_ff;
      sat_ff[0] <= sat_in;
      for (int s = 0; s < NS; s++) begin
         rem_ff[s+1] <= rem_in[s];
         quo_ff[s+1] <= quo_in[s];
         neg_ff[s+1] <= neg_ff[s];
         sat_ff[s+1] <= sat_ff[s];
      end
   end

   // apply sign and saturation
   always_ff @(posedge clock) begin
      if (sat_ff[NS]) begin
         quot <= neg_ff[NS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (neg_ff[NS]) begin
         quot <= -signed'({1'b0, quo_ff[NS]});
      end else begin
         quot <= signed'({1'b0, quo_ff[NS]});
      end
   end

endmodule

/* rtl/bptc_mulq.sv */
// three-stage Q30 multiplier: |a*q| / 2^30 truncated, with the sign of the product
// depends on bptc_pkg
module bptc_mulq (
   input  logic                                clock,
   input  bptc_pkg::acc_type                   a,
   input  logic signed [bptc_pkg::Q_W-1:0]     q,
   output logic        [bptc_pkg::MAG_W-1:0]   mag,
   output logic                                neg
);

   localparam int AW = bptc_pkg::ACC_W;
   localparam int LW = AW / 2;
   localparam int QW = bptc_pkg::Q_W;
   localparam int PW = LW + QW;
   localparam int SW = AW + QW;

   logic [AW-1:0] ua_ff;
   logic [QW-1:0] uq_ff;
   logic          n0_ff;
   logic [PW-1:0] ph_ff;
   logic [PW-1:0] pl_ff;
   logic          n1_ff;
   logic [SW-1:0] sum;

   // magnitudes
   always_ff @(posedge clock) begin
      ua_ff <= a[AW-1] ? AW'(-a) : AW'(a);
      uq_ff <= q[QW-1] ? QW'(-q) : QW'(q);
      n0_ff <= a[AW-1] ^ q[QW-1];
   end

   // two partial products of the split operand
   always_ff @(posedge clock) begin
      ph_ff <= ua_ff[AW-1:LW] * uq_ff;
      pl_ff <= ua_ff[LW-1:0] * uq_ff;
      n1_ff <= n0_ff;
   end

   // recombine and drop the 30 fraction bits
   assign sum = {ph_ff, {LW{1'b0}}} + SW'(pl_ff);

   always_ff @(posedge clock) begin
      mag <= sum[bptc_pkg::MAG_W+29:30];
      neg <= n1_ff;
   end

endmodule

/* rtl/baro_pressure_temp_compensation_core.sv */
// barometric compensation core: one item may start in every cycle, busy stays low
// from start to rsp_valid an item passes the pipelined dividers, the exact innermost
// products and their sums, then two Q30 multiply levels (each the multiplier stages and
// one register to add the coefficient), then the final sum and rounding
// throughput one item per cycle; results cannot be held off by the receiver
// synchronous reset clears the pipeline valid bits and loads the csr reset values
module baro_pressure_temp_compensation_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [bptc_pkg::RAW_W-1:0]        req_pressure_raw,
   input  logic signed [bptc_pkg::RAW_W-1:0]        req_temperature_raw,
   output logic                                     rsp_valid,
   output logic signed [bptc_pkg::TEMP_W-1:0]       rsp_temperature_centi,
   output logic        [bptc_pkg::PRESS_W-1:0]      rsp_pressure_q4,
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic        [bptc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic        [bptc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic        [bptc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                     pready
);

   localparam int LAT = bptc_pkg::LATENCY;
   localparam int QW  = bptc_pkg::Q_W;

   logic                    accept;
   bptc_pkg::reg_idx_type   reg_idx;

   logic [23:0] raw_scale_ff;
   logic [23:0] temp_coeffs_ff;
   logic [39:0] pbase_ff;
   logic [31:0] pcross_ff;
   logic [31:0] psecond_ff;
   logic [15:0] pcubic_ff;

   logic [23:0]        div_scale;
   logic signed [11:0] c0, c1;
   logic signed [19:0] c00, c10;
   logic signed [15:0] c01, c11, c20, c21, c30;

   logic signed [QW-1:0] p_q, t_q;
   logic signed [QW-1:0] pd_ff [0:5];
   logic signed [QW-1:0] td_ff [0:5];

   logic [LAT-2:0] vld_ff;

   logic signed [47:0] m30_ff, m21_ff;
   logic signed [43:0] tprod_ff;
   bptc_pkg::acc_type  acc1_ff, cross1_ff, acc2_ff, cross2_ff, acc3_ff, crt_ff, s_ff;
   logic signed [44:0] tq_ff;
   logic signed [51:0] t100_ff;
   logic signed [51:0] tq_ext;
   logic signed [21:0] tdiv_ff;
   logic signed [15:0] tsat_ff;
   logic signed [15:0] tdly_ff [0:6];
   logic               pos_ff;
   logic [29:0]        rnd_ff;

   logic [bptc_pkg::MAG_W-1:0] mag_a, mag_b, mag_c, mag_d;
   logic                       neg_a, neg_b, neg_c, neg_d;

   // handshake: the pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign pready = 1'b1;

   // csr write and read
   assign reg_idx = bptc_pkg::reg_idx_type'(paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_scale_ff   <= bptc_pkg::RAW_SCALE_RESET;
         temp_coeffs_ff <= '0;
         pbase_ff       <= '0;
         pcross_ff      <= '0;
         psecond_ff     <= '0;
         pcubic_ff      <= '0;
      end else if (psel && penable && pwrite && pready) begin
         case (reg_idx)
            bptc_pkg::REG_RAW_SCALE: raw_scale_ff   <= pwdata[23:0];
            bptc_pkg::REG_TEMP:      temp_coeffs_ff <= pwdata[23:0];
            bptc_pkg::REG_PBASE:     pbase_ff       <= pwdata[39:0];
            bptc_pkg::REG_PCROSS:    pcross_ff      <= pwdata[31:0];
            bptc_pkg::REG_PSECOND:   psecond_ff     <= pwdata[31:0];
            bptc_pkg::REG_PCUBIC:    pcubic_ff      <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         bptc_pkg::REG_RAW_SCALE: prdata = 64'(raw_scale_ff);
         bptc_pkg::REG_TEMP:      prdata = 64'(temp_coeffs_ff);
         bptc_pkg::REG_PBASE:     prdata = 64'(pbase_ff);
         bptc_pkg::REG_PCROSS:    prdata = 64'(pcross_ff);
         bptc_pkg::REG_PSECOND:   prdata = 64'(psecond_ff);
         bptc_pkg::REG_PCUBIC:    prdata = 64'(pcubic_ff);
         default:                 prdata = '0;
      endcase
   end

   // coefficient fields; a zero divisor counts as one
   assign div_scale = (raw_scale_ff == '0) ? 24'd1 : raw_scale_ff;
   assign c0  = signed'(temp_coeffs_ff[23:12]);
   assign c1  = signed'(temp_coeffs_ff[11:0]);
   assign c00 = signed'(pbase_ff[39:20]);
   assign c10 = signed'(pbase_ff[19:0]);
   assign c01 = signed'(pcross_ff[31:16]);
   assign c11 = signed'(pcross_ff[15:0]);
   assign c20 = signed'(psecond_ff[31:16]);
   assign c21 = signed'(psecond_ff[15:0]);
   assign c30 = signed'(pcubic_ff);

   // valid bits follow the item through every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         vld_ff    <= {vld_ff[LAT-3:0], accept};
         rsp_valid <= vld_ff[LAT-2];
      end
   end

   // scaling of both readings to Q2.30
   bptc_div u_div_p (
      .clock   (clock),
      .raw     (req_pressure_raw),
      .divisor (div_scale),
      .quot    (p_q)
   );

   bptc_div u_div_t (
      .clock   (clock),
      .raw     (req_temperature_raw),
      .divisor (div_scale),
      .quot    (t_q)
   );

   // delay lines for p and t alongside the Horner chain
   always_ff @(posedge clock) begin
      pd_ff[0] <= p_q;
      td_ff[0] <= t_q;
      for (int i = 1; i < 6; i++) begin
         pd_ff[i] <= pd_ff[i-1];
         td_ff[i] <= td_ff[i-1];
      end
   end

   // exact products with the plain coefficients
   always_ff @(posedge clock) begin
      m30_ff   <= c30 * p_q;
      m21_ff   <= c21 * p_q;
      tprod_ff <= t_q * c1;
   end

   // innermost Horner terms and the temperature sum
   always_ff @(posedge clock) begin
      acc1_ff   <= (bptc_pkg::acc_type'(c20) <<< 30) + bptc_pkg::acc_type'(m30_ff);
      cross1_ff <= (bptc_pkg::acc_type'(c11) <<< 30) + bptc_pkg::acc_type'(m21_ff);
      tq_ff     <= (45'(c0) <<< 29) + 45'(tprod_ff);
   end

   // temperature: times 100, truncate toward zero, saturate
   assign tq_ext = 52'(tq_ff);

   always_ff @(posedge clock) begin
      t100_ff <= (tq_ext <<< 6) + (tq_ext <<< 5) + (tq_ext <<< 2);
      tdiv_ff <= 22'((t100_ff + (t100_ff[51] ? 52'sd1073741823 : 52'sd0)) >>> 30);
      if (tdiv_ff > 22'sd32767) begin
         tsat_ff <= 16'sh7FFF;
      end else if (tdiv_ff < -22'sd32768) begin
         tsat_ff <= 16'sh8000;
      end else begin
         tsat_ff <= tdiv_ff[15:0];
      end
      tdly_ff[0] <= tsat_ff;
      for (int i = 1; i < 7; i++) begin
         tdly_ff[i] <= tdly_ff[i-1];
      end
      rsp_temperature_centi <= tdly_ff[6];
   end

   // second Horner level
   bptc_mulq u_mul_a (.clock(clock), .a(acc1_ff), .q(pd_ff[1]), .mag(mag_a), .neg(neg_a));
   bptc_mulq u_mul_b (.clock(clock), .a(cross1_ff), .q(pd_ff[1]), .mag(mag_b), .neg(neg_b));

   always_ff @(posedge clock) begin
      acc2_ff   <= (bptc_pkg::acc_type'(c10) <<< 30)
                   + (neg_a ? -bptc_pkg::acc_type'(mag_a) : bptc_pkg::acc_type'(mag_a));
      cross2_ff <= (bptc_pkg::acc_type'(c01) <<< 30)
                   + (neg_b ? -bptc_pkg::acc_type'(mag_b) : bptc_pkg::acc_type'(mag_b));
   end

   // outer level and temperature cross term
   bptc_mulq u_mul_c (.clock(clock), .a(acc2_ff), .q(pd_ff[5]), .mag(mag_c), .neg(neg_c));
   bptc_mulq u_mul_d (.clock(clock), .a(cross2_ff), .q(td_ff[5]), .mag(mag_d), .neg(neg_d));

   always_ff @(posedge clock) begin
      acc3_ff <= (bptc_pkg::acc_type'(c00) <<< 30)
                 + (neg_c ? -bptc_pkg::acc_type'(mag_c) : bptc_pkg::acc_type'(mag_c));
      crt_ff  <= neg_d ? -bptc_pkg::acc_type'(mag_d) : bptc_pkg::acc_type'(mag_d);
      s_ff    <= acc3_ff + crt_ff;
   end

   // round to nearest, clamp to the output range
   always_ff @(posedge clock) begin
      pos_ff <= s_ff > 0;
      rnd_ff <= 30'((s_ff + (bptc_pkg::acc_type'(1) <<< 25)) >>> 26);
      if (!pos_ff) begin
         rsp_pressure_q4 <= '0;
      end else if (rnd_ff > 30'(bptc_pkg::PRESS_MAX)) begin
         rsp_pressure_q4 <= bptc_pkg::PRESS_MAX;
      end else begin
         rsp_pressure_q4 <= rnd_ff[bptc_pkg::PRESS_W-1:0];
      end
   end

endmodule

/* rtl/bptc_checker.sv */
// port-level checks for the compensation core, bound to the top level
// depends on bptc_pkg and the macro header
`include "baro_pressure_temp_compensation_core_macros.svh"

module bptc_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic                                   rsp_valid,
   input logic                                   psel,
   input logic                                   penable,
   input logic                                   pready
);

   localparam int LAT = bptc_pkg::LATENCY;

   // every accepted item leaves after the fixed latency
   `BPTC_ASSERT_RST(a_item_out, clock, reset, (start && !busy) |-> ##LAT rsp_valid)
   // no result without an item accepted that many cycles before
   `BPTC_ASSERT_RST(a_no_spurious, clock, reset, rsp_valid |-> $past(start && !busy, LAT))
   // reset empties the pipeline
   `BPTC_ASSERT_ALL(a_reset_flush, clock, reset |=> !rsp_valid)
   // the core always takes items and csr accesses
   `BPTC_ASSERT_RST(a_always_ready, clock, reset, (psel && penable) |-> (pready && !busy))

endmodule

bind baro_pressure_temp_compensation_core bptc_checker u_bptc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .psel            (psel),
   .penable         (penable),
   .pready          (pready)
);
